// ----- design/lesq_pkg.sv -----
// ----------------------------------------------------------------------------
// lesq_pkg - shared types and constants for the largest empty square scan
// Field widths, reset values and the per-cell tag that travels with a beat.
// ----------------------------------------------------------------------------
package lesq_pkg;

    localparam int unsigned SIDE_W       = 11;           // run and side width
    localparam int unsigned GRID_W       = 11;           // grid_size register width
    localparam int unsigned LINE_W       = 2 * SIDE_W;   // {up run, side} per column
    localparam int unsigned MAX_SIZE_DEF = 1024;
    localparam logic [GRID_W-1:0] GRID_RESET = 11'd1024;

    // Tag carried from the raster counters to the cell arithmetic
    typedef struct packed {
        logic blocked;
        logic first_row;
        logic first_col;
        logic frame_end;
    } t_cell_flags;

endpackage

// ----- design/largest_empty_square_scan.sv -----
// ----------------------------------------------------------------------------
// largest_empty_square_scan - maximal free square over a raster grid
// Per cell: square side ending there, running best side, last-cell mark.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  ---------------------------------
//  cfg      in         i_cfg_we                i_cfg_data (grid_size)
//  in       in         i_in_valid / o_in_stall i_cell_blocked
//  out      out        o_out_valid/i_out_stall o_square_side, o_best_side,
//                                              o_frame_done
//
//  One cell per clock sustained while the output is not stalled; the result
//  reaches the output register after the read stage (store read on the
//  accepting edge, then arithmetic and write-back, the write forwarded to the
//  following beat's read). Reset clears counters, runs, best side and valid
//  flags and sets grid_size to 1024; the line store is not cleared.
//  The input stalls only while the read stage is full and the output is stalled.
//
module largest_empty_square_scan #(
    parameter int unsigned MAX_SIZE = lesq_pkg::MAX_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lesq_pkg::GRID_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cell_blocked,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lesq_pkg::SIDE_W-1:0] o_square_side,
    output logic [lesq_pkg::SIDE_W-1:0] o_best_side,
    output logic                        o_frame_done
);

    localparam int unsigned AW = $clog2(MAX_SIZE);

    // read stage -> arithmetic stage
    logic                        s1_valid;
    logic                        s1_fire;
    logic [AW-1:0]               s1_col;
    lesq_pkg::t_cell_flags       s1_flags;

    // line store ports
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [lesq_pkg::LINE_W-1:0] rd_data;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [lesq_pkg::LINE_W-1:0] wr_data;

    lesq_scan_ctrl #(
        .MAX_SIZE (MAX_SIZE),
        .AW       (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cell_blocked (i_cell_blocked),
        .i_s1_fire      (s1_fire),
        .o_s1_valid     (s1_valid),
        .o_s1_col       (s1_col),
        .o_s1_flags     (s1_flags),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr)
    );

    // {up run, side} for every column of the previous row
    lesq_line_mem #(
        .MAX_SIZE (MAX_SIZE),
        .AW       (AW)
    ) u_line (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    lesq_cell_calc #(
        .MAX_SIZE (MAX_SIZE),
        .AW       (AW)
    ) u_calc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1_valid    (s1_valid),
        .i_s1_col      (s1_col),
        .i_s1_flags    (s1_flags),
        .i_rd_data     (rd_data),
        .o_s1_fire     (s1_fire),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_square_side (o_square_side),
        .o_best_side   (o_best_side),
        .o_frame_done  (o_frame_done)
    );

    // input only backs up when both stages hold a beat and the sink stalls
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (s1_valid && o_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

    // running best never trails the side it was formed from
    a_best_covers_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_best_side >= o_square_side))
        else $error("best side below current side");

    // the line store is written only as a beat leaves the read stage
    a_write_with_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (s1_valid && wr_addr == s1_col))
        else $error("line store write without a beat");

endmodule

// ----- design/lesq_line_mem.sv -----
// ----------------------------------------------------------------------------
// lesq_line_mem - line store for the up run and the previous row's side
// One write port, one registered read port with read enable.
// ----------------------------------------------------------------------------
module lesq_line_mem #(
    parameter int unsigned MAX_SIZE = lesq_pkg::MAX_SIZE_DEF,
    parameter int unsigned AW       = $clog2(MAX_SIZE)
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [lesq_pkg::LINE_W-1:0] o_rd_data,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [lesq_pkg::LINE_W-1:0] i_wr_data
);

    logic [lesq_pkg::LINE_W-1:0] r_mem [MAX_SIZE];
    logic [lesq_pkg::LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // old data on a same-address read and write; caller forwards
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/lesq_scan_ctrl.sv -----
// ----------------------------------------------------------------------------
// lesq_scan_ctrl - raster position counters and the read stage
// Holds grid_size, tracks row and column, issues the line store read and
// keeps the beat's column and flags for the arithmetic stage.
// ----------------------------------------------------------------------------
module lesq_scan_ctrl #(
    parameter int unsigned MAX_SIZE = lesq_pkg::MAX_SIZE_DEF,
    parameter int unsigned AW       = $clog2(MAX_SIZE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lesq_pkg::GRID_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cell_blocked,
    input  logic                        i_s1_fire,
    output logic                        o_s1_valid,
    output logic [AW-1:0]               o_s1_col,
    output lesq_pkg::t_cell_flags       o_s1_flags,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr
);

    localparam int unsigned CMP_W = (AW + 1 > lesq_pkg::GRID_W) ? AW + 1 : lesq_pkg::GRID_W;

    logic [lesq_pkg::GRID_W-1:0] r_grid_size;
    logic [AW-1:0]               r_col, n_col;
    logic [AW-1:0]               r_row, n_row;
    logic                        r_s1_valid;
    logic [AW-1:0]               r_s1_col;
    lesq_pkg::t_cell_flags       r_s1_flags;

    logic [CMP_W-1:0]      gs_ext;
    logic [AW-1:0]         last;
    logic [AW-1:0]         col_eff;
    logic [AW-1:0]         row_eff;
    logic                  row_end;
    logic                  accept;
    lesq_pkg::t_cell_flags flags;

    always_comb begin
        gs_ext = CMP_W'(r_grid_size);
        if (gs_ext == '0) begin
            last = '0;
        end else if (gs_ext > CMP_W'(MAX_SIZE)) begin
            last = AW'(MAX_SIZE - 1);
        end else begin
            last = AW'(gs_ext - CMP_W'(1));
        end
    end

    always_comb begin
        col_eff = (r_col > last) ? last : r_col;
        row_eff = (r_row > last) ? last : r_row;
        row_end = (col_eff == last);

        flags.blocked   = i_cell_blocked;
        flags.first_row = (row_eff == '0);
        flags.first_col = (col_eff == '0);
        flags.frame_end = row_end && (row_eff == last);

        n_col = r_col;
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = flags.frame_end ? '0 : row_eff + AW'(1);
        end else begin
            n_col = col_eff + AW'(1);
            n_row = row_eff;
        end
    end

    assign o_in_stall = r_s1_valid && !i_s1_fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= lesq_pkg::GRID_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_grid_size <= i_cfg_data;
            end
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (i_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col   <= col_eff;
            r_s1_flags <= flags;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_col   = r_s1_col;
    assign o_s1_flags = r_s1_flags;
    assign o_rd_en    = accept;
    assign o_rd_addr  = col_eff;

endmodule

// ----- design/lesq_cell_calc.sv -----
// ----------------------------------------------------------------------------
// lesq_cell_calc - square side arithmetic, write-back and output register
// Forms the runs and the side from the line store data, writes them back,
// keeps the left run, diagonal side and best side, and holds the result beat.
// ----------------------------------------------------------------------------
module lesq_cell_calc #(
    parameter int unsigned MAX_SIZE = lesq_pkg::MAX_SIZE_DEF,
    parameter int unsigned AW       = $clog2(MAX_SIZE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s1_valid,
    input  logic [AW-1:0]               i_s1_col,
    input  lesq_pkg::t_cell_flags       i_s1_flags,
    input  logic [lesq_pkg::LINE_W-1:0] i_rd_data,
    output logic                        o_s1_fire,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output logic [lesq_pkg::LINE_W-1:0] o_wr_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lesq_pkg::SIDE_W-1:0] o_square_side,
    output logic [lesq_pkg::SIDE_W-1:0] o_best_side,
    output logic                        o_frame_done
);

    localparam int unsigned SW = lesq_pkg::SIDE_W;

    logic [SW-1:0]               r_left;
    logic [SW-1:0]               r_diag;
    logic [SW-1:0]               r_best;
    logic                        r_fwd_valid;
    logic [AW-1:0]               r_fwd_addr;
    logic [lesq_pkg::LINE_W-1:0] r_fwd_data;
    logic                        r_out_valid;
    logic [SW-1:0]               r_out_side;
    logic [SW-1:0]               r_out_best;
    logic                        r_out_done;

    logic [lesq_pkg::LINE_W-1:0] line;
    logic [SW-1:0] up_prev, old_side, diag, left_prev;
    logic [SW-1:0] left, up, diag_inc, side, best;

    assign o_s1_fire = i_s1_valid && (!r_out_valid || !i_out_stall);

    // previous beat's write lands on the same edge as this beat's read
    assign line = (r_fwd_valid && r_fwd_addr == i_s1_col) ? r_fwd_data : i_rd_data;

    always_comb begin
        up_prev   = i_s1_flags.first_row ? '0 : line[lesq_pkg::LINE_W-1:SW];
        old_side  = i_s1_flags.first_row ? '0 : line[SW-1:0];
        diag      = (i_s1_flags.first_row || i_s1_flags.first_col) ? '0 : r_diag;
        left_prev = i_s1_flags.first_col ? '0 : r_left;
        diag_inc  = diag + SW'(1);
        if (i_s1_flags.blocked) begin
            left = '0;
            up   = '0;
            side = '0;
        end else begin
            left = left_prev + SW'(1);
            up   = up_prev + SW'(1);
            side = (left < up) ? left : up;
            if (diag_inc < side) begin
                side = diag_inc;
            end
        end
        best = (side > r_best) ? side : r_best;
    end

    assign o_wr_en   = o_s1_fire;
    assign o_wr_addr = i_s1_col;
    assign o_wr_data = {up, side};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best      <= '0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s1_fire) begin
                r_left      <= left;
                r_diag      <= old_side;
                r_best      <= i_s1_flags.frame_end ? '0 : best;
                r_fwd_valid <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_fire) begin
            r_fwd_addr <= i_s1_col;
            r_fwd_data <= {up, side};
            r_out_side <= side;
            r_out_best <= best;
            r_out_done <= i_s1_flags.frame_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_square_side = r_out_side;
    assign o_best_side   = r_out_best;
    assign o_frame_done  = r_out_done;

endmodule
